[src/round_robin_ready_queue_defines.svh]
// assertion macros for the round robin ready queue
// used by modules that carry concurrent checks; expects clk and arst_n in scope
`ifndef ROUND_ROBIN_READY_QUEUE_DEFINES_SVH
`define ROUND_ROBIN_READY_QUEUE_DEFINES_SVH

// property must hold at every clock edge outside reset
`define RRQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be true outside reset
`define RRQ_NEVER(lbl, cond, msg) \
	`RRQ_ASSERT(lbl, !(cond), msg)

`endif

[src/rrq_pkg.sv]
// shared types and codes for the round robin ready queue
// used by the controller, the datapath and the top level; depends on nothing
package rrq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_W     = 8;
	localparam int MODE_W   = 2;
	localparam int KIND_W   = 3;
	localparam int ID_SEL_W = 2;

	localparam logic [MODE_W-1:0] MODE_YIELD     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RESUME    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TERMINATE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_PREEMPT   = 2'd3;

	localparam logic [KIND_W-1:0] K_RECLAIMED = 3'd0;
	localparam logic [KIND_W-1:0] K_DISPATCH  = 3'd1;
	localparam logic [KIND_W-1:0] K_NOTHING   = 3'd2;
	localparam logic [KIND_W-1:0] K_IGNORED   = 3'd3;
	localparam logic [KIND_W-1:0] K_QFULL     = 3'd4;
	localparam logic [KIND_W-1:0] K_ZFULL     = 3'd5;

	localparam logic [ID_SEL_W-1:0] ID_ZERO     = 2'd0;
	localparam logic [ID_SEL_W-1:0] ID_DISPATCH = 2'd1;
	localparam logic [ID_SEL_W-1:0] ID_RECLAIM  = 2'd2;

	localparam logic [ID_W-1:0] IDLE_ID_RST = 8'd255;

	typedef struct packed {
		logic take;
		logic rd_head;
		logic zrd_top;
		logic zrd_next;
		logic zpush;
		logic zpop;
		logic enq;
		logic enq_cur;
		logic pop;
		logic dispatch;
		logic scan_start;
		logic scan_step;
		logic term_commit;
		logic emit;
		logic last;
		logic [ID_SEL_W-1:0] id_sel;
		logic [KIND_W-1:0]   kind;
	} rrq_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic out_free;
		logic cur_present;
		logic tgt_ign;
		logic q_empty;
		logic q_full;
		logic z_empty;
		logic z_one;
		logic z_full;
		logic cur_hit;
		logic cur_idle;
		logic scan_done;
		logic term_hit;
	} rrq_status_t;

endpackage

[src/rrq_ctrl.sv]
// sequencing state machine of the round robin ready queue
// depends on rrq_pkg; drives commands into rrq_datapath and reads its status
module rrq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rrq_pkg::rrq_status_t status,
	output rrq_pkg::rrq_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_FIN    = 3'd2;
	localparam logic [2:0] S_YEMIT  = 3'd3;
	localparam logic [2:0] S_DEMIT  = 3'd4;
	localparam logic [2:0] S_RFIN   = 3'd5;
	localparam logic [2:0] S_SCAN   = 3'd6;
	localparam logic [2:0] S_TFIN   = 3'd7;

	logic [2:0] state_q, state_d;
	logic [rrq_pkg::KIND_W-1:0] kind_q, kind_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		kind_d   = kind_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (status.mode)
					rrq_pkg::MODE_YIELD: begin
						if (status.q_empty && status.cur_idle) begin
							kind_d  = rrq_pkg::K_NOTHING;
							state_d = S_FIN;
						end else begin
							cmd.rd_head = 1'b1;
							state_d     = S_YEMIT;
						end
					end
					rrq_pkg::MODE_RESUME: begin
						cmd.zrd_top = 1'b1;
						state_d     = status.z_empty ? S_RFIN : S_DEMIT;
					end
					rrq_pkg::MODE_TERMINATE: begin
						if (status.tgt_ign) begin
							kind_d  = rrq_pkg::K_IGNORED;
							state_d = S_FIN;
						end else if (status.z_full) begin
							kind_d  = rrq_pkg::K_ZFULL;
							state_d = S_FIN;
						end else if (status.cur_hit) begin
							cmd.zpush   = 1'b1;
							cmd.rd_head = 1'b1;
							state_d     = S_YEMIT;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					default: begin
						if (!status.cur_present) begin
							kind_d  = rrq_pkg::K_IGNORED;
							state_d = S_FIN;
						end else if (status.q_empty) begin
							kind_d  = rrq_pkg::K_NOTHING;
							state_d = S_FIN;
						end else begin
							cmd.zrd_top = 1'b1;
							state_d     = status.z_empty ? S_RFIN : S_DEMIT;
						end
					end
				endcase
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.emit   = 1'b1;
					cmd.kind   = kind_q;
					cmd.id_sel = rrq_pkg::ID_ZERO;
					cmd.last   = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_YEMIT: begin
				if (status.out_free) begin
					cmd.emit     = 1'b1;
					cmd.kind     = rrq_pkg::K_DISPATCH;
					cmd.id_sel   = rrq_pkg::ID_DISPATCH;
					cmd.last     = 1'b1;
					cmd.dispatch = 1'b1;
					cmd.pop      = !status.q_empty;
					state_d      = S_IDLE;
				end
			end
			S_DEMIT: begin
				if (status.out_free) begin
					cmd.emit   = 1'b1;
					cmd.kind   = rrq_pkg::K_RECLAIMED;
					cmd.id_sel = rrq_pkg::ID_RECLAIM;
					cmd.zpop   = 1'b1;
					if (status.z_one) begin
						state_d = S_RFIN;
					end else begin
						cmd.zrd_next = 1'b1;
					end
				end
			end
			S_RFIN: begin
				if (status.mode == rrq_pkg::MODE_RESUME) begin
					if (status.out_free) begin
						cmd.emit   = 1'b1;
						cmd.id_sel = rrq_pkg::ID_ZERO;
						cmd.last   = 1'b1;
						if (status.tgt_ign) begin
							cmd.kind = rrq_pkg::K_IGNORED;
						end else if (status.q_full) begin
							cmd.kind = rrq_pkg::K_QFULL;
						end else begin
							cmd.kind = rrq_pkg::K_NOTHING;
							cmd.enq  = 1'b1;
						end
						state_d = S_IDLE;
					end
				end else if (status.cur_idle) begin
					cmd.rd_head = 1'b1;
					state_d     = S_YEMIT;
				end else if (status.q_full) begin
					kind_d  = rrq_pkg::K_QFULL;
					state_d = S_FIN;
				end else begin
					cmd.enq     = 1'b1;
					cmd.enq_cur = 1'b1;
					cmd.rd_head = 1'b1;
					state_d     = S_YEMIT;
				end
			end
			S_SCAN: begin
				if (status.scan_done) begin
					state_d = S_TFIN;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_TFIN: begin
				if (status.out_free) begin
					cmd.emit        = 1'b1;
					cmd.kind        = status.term_hit ? rrq_pkg::K_NOTHING : rrq_pkg::K_IGNORED;
					cmd.id_sel      = rrq_pkg::ID_ZERO;
					cmd.last        = 1'b1;
					cmd.term_commit = 1'b1;
					cmd.zpush       = status.term_hit;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= rrq_pkg::K_NOTHING;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

endmodule

[src/rrq_datapath.sv]
// ready ring, zombie stack, counters, running register and result register
// depends on rrq_pkg and round_robin_ready_queue_defines.svh; driven by rrq_ctrl
`include "round_robin_ready_queue_defines.svh"

module rrq_datapath #(
	parameter int QUEUE_DEPTH = rrq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rrq_pkg::rrq_cmd_t                 cmd,
	output rrq_pkg::rrq_status_t              status,
	input  logic [rrq_pkg::MODE_W-1:0]        mode,
	input  logic                              thread_present,
	input  logic [rrq_pkg::ID_W-1:0]          thread_id,
	input  logic                              current_present,
	input  logic [rrq_pkg::ID_W-1:0]          current_id,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rrq_pkg::ID_W-1:0]          cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rrq_pkg::KIND_W-1:0]        kind,
	output logic [rrq_pkg::ID_W-1:0]          out_id,
	output logic                              last,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]  ready_count
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int IW = rrq_pkg::ID_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [CW-1:0] TWO_C   = CW'(2);

	function automatic logic [AW-1:0] ring_addr(input logic [SW-1:0] s);
		logic [SW-1:0] w;
		w = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
		return w[AW-1:0];
	endfunction

	logic [rrq_pkg::MODE_W-1:0] mode_q;
	logic                       tp_q, cp_q;
	logic [IW-1:0]              tid_q, cid_q;
	logic [IW-1:0]              idle_q;
	logic [AW-1:0]              head_q;
	logic [CW-1:0]              cnt_q, zcnt_q, fin_cnt_q;
	logic [IW-1:0]              run_q;
	logic                       run_v_q;

	logic [IW-1:0] ring_mem [QUEUE_DEPTH];
	logic [IW-1:0] zomb_mem [QUEUE_DEPTH];
	logic [IW-1:0] ring_rd_q, zomb_rd_q;

	logic [CW-1:0] idx_q, chk_idx_q;
	logic          chk_q, found_q;

	logic                       out_valid_q, last_q;
	logic [rrq_pkg::KIND_W-1:0] kind_q;
	logic [IW-1:0]              out_id_q;
	logic [CW-1:0]              rcnt_q;

	logic          q_empty, q_full, out_free, issue, match, shift_we;
	logic          ring_we, ring_re, zomb_re;
	logic [AW-1:0] ring_wa, ring_ra, zomb_ra;
	logic [IW-1:0] ring_wd, id_d;
	logic [CW-1:0] cnt_dec, fin_d, zaddr_c;

	assign q_empty  = (cnt_q == '0);
	assign q_full   = (cnt_q == DEPTH_C);
	assign out_free = !out_valid_q || out_ready;
	assign cnt_dec  = q_empty ? cnt_q : (cnt_q - ONE_C);

	assign issue    = cmd.scan_step && (idx_q < cnt_q);
	assign match    = cmd.scan_step && chk_q && !found_q && (ring_rd_q == tid_q);
	assign shift_we = cmd.scan_step && chk_q && found_q;

	always_comb begin
		status             = '0;
		status.mode        = mode_q;
		status.out_free    = out_free;
		status.cur_present = cp_q;
		status.tgt_ign     = !tp_q || (tid_q == idle_q);
		status.q_empty     = q_empty;
		status.q_full      = q_full;
		status.z_empty     = (zcnt_q == '0);
		status.z_one       = (zcnt_q == ONE_C);
		status.z_full      = (zcnt_q == DEPTH_C);
		status.cur_hit     = cp_q && (tid_q == cid_q);
		status.cur_idle    = cp_q && (cid_q == idle_q);
		status.scan_done   = !(idx_q < cnt_q) && !chk_q;
		status.term_hit    = found_q || (run_v_q && (tid_q == run_q));
	end

	// result count after the whole item, set from the item and state at intake and lowered on a terminate scan match
	always_comb begin
		case (mode)
			rrq_pkg::MODE_YIELD: begin
				fin_d = cnt_dec;
			end
			rrq_pkg::MODE_RESUME: begin
				fin_d = (thread_present && (thread_id != idle_q) && !q_full)
					? (cnt_q + ONE_C) : cnt_q;
			end
			rrq_pkg::MODE_TERMINATE: begin
				fin_d = (thread_present && (thread_id != idle_q) && (zcnt_q != DEPTH_C)
					&& current_present && (thread_id == current_id)) ? cnt_dec : cnt_q;
			end
			default: begin
				fin_d = (current_present && !q_empty && (current_id == idle_q))
					? (cnt_q - ONE_C) : cnt_q;
			end
		endcase
	end

	always_comb begin
		ring_we = cmd.enq || shift_we;
		ring_re = cmd.rd_head || issue;
		if (cmd.enq) begin
			ring_wa = ring_addr(SW'(head_q) + SW'(cnt_q));
			ring_wd = cmd.enq_cur ? cid_q : tid_q;
		end else begin
			ring_wa = ring_addr(SW'(head_q) + SW'(chk_idx_q) - SW'(1));
			ring_wd = ring_rd_q;
		end
		ring_ra = cmd.rd_head ? head_q : ring_addr(SW'(head_q) + SW'(idx_q));
		zomb_re = cmd.zrd_top || cmd.zrd_next;
		zaddr_c = cmd.zrd_top ? (zcnt_q - ONE_C) : (zcnt_q - TWO_C);
		zomb_ra = zaddr_c[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_wa] <= ring_wd;
		end
		if (ring_re) begin
			ring_rd_q <= ring_mem[ring_ra];
		end
		if (cmd.zpush) begin
			zomb_mem[zcnt_q[AW-1:0]] <= tid_q;
		end
		if (zomb_re) begin
			zomb_rd_q <= zomb_mem[zomb_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q <= mode;
			tp_q   <= thread_present;
			tid_q  <= thread_id;
			cp_q   <= current_present;
			cid_q  <= current_id;
		end
		if (cmd.take) begin
			fin_cnt_q <= fin_d;
		end else if (match) begin
			fin_cnt_q <= fin_cnt_q - ONE_C;
		end
		if (issue) begin
			chk_idx_q <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q  <= rrq_pkg::IDLE_ID_RST;
			head_q  <= '0;
			cnt_q   <= '0;
			zcnt_q  <= '0;
			run_q   <= '0;
			run_v_q <= 1'b0;
			idx_q   <= '0;
			chk_q   <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				idle_q <= cfg_data;
			end
			if (cmd.pop) begin
				head_q <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : (head_q + AW'(1));
			end
			if (cmd.enq) begin
				cnt_q <= cnt_q + ONE_C;
			end else if (cmd.pop || (cmd.term_commit && found_q)) begin
				cnt_q <= cnt_q - ONE_C;
			end
			if (cmd.zpush) begin
				zcnt_q <= zcnt_q + ONE_C;
			end else if (cmd.zpop) begin
				zcnt_q <= zcnt_q - ONE_C;
			end
			if (cmd.dispatch) begin
				run_q   <= id_d;
				run_v_q <= 1'b1;
			end
			if (cmd.scan_start) begin
				idx_q   <= '0;
				chk_q   <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				chk_q <= issue;
				if (issue) begin
					idx_q <= idx_q + ONE_C;
				end
				if (match) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		case (cmd.id_sel)
			rrq_pkg::ID_DISPATCH: id_d = q_empty ? idle_q : ring_rd_q;
			rrq_pkg::ID_RECLAIM:  id_d = zomb_rd_q;
			default:              id_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q   <= cmd.kind;
			out_id_q <= id_d;
			last_q   <= cmd.last;
			rcnt_q   <= fin_cnt_q;
		end
	end

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign out_id      = out_id_q;
	assign last        = last_q;
	assign ready_count = rcnt_q;

	`RRQ_ASSERT(a_cnt_bound, (cnt_q <= DEPTH_C) && (zcnt_q <= DEPTH_C), "count beyond depth")
	`RRQ_ASSERT(a_emit_free, cmd.emit |-> out_free, "result beat overwrites a held result")
	`RRQ_ASSERT(a_dispatch_run, (cmd.emit && cmd.dispatch) |=> (run_v_q && (run_q == out_id_q)), "running id differs from dispatch")
	`RRQ_NEVER(a_enq_full, cmd.enq && q_full, "enqueue into a full ready ring")
	`RRQ_NEVER(a_push_full, cmd.zpush && (zcnt_q == DEPTH_C), "push onto a full zombie stack")

endmodule

[src/round_robin_ready_queue.sv]
// top level of the round robin ready queue thread scheduler
// depends on rrq_pkg, rrq_ctrl and rrq_datapath
//
//  channel  handshake              beat contents
//  in       in_valid / in_ready    mode, thread_present, thread_id, current_present, current_id
//  out      out_valid / out_ready  kind, out_id, last, ready_count
//  cfg      cfg_valid / cfg_ready  cfg_data (idle thread id)
//
// one item at a time; a new item is taken only once the last result beat of the one before is loaded
// yield reads the ready ring head, then loads the dispatch beat
// resume and preempt read the zombie stack top and load one beat per reclaimed zombie before the last
// terminate of a non-current id scans the ready ring entry by entry, then loads the last beat
// reset clears counts, pointers and the running flag; no memory clearing pass
// a held result stalls only the next result beat, intake of a new item goes on
module round_robin_ready_queue #(
	parameter int QUEUE_DEPTH = rrq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rrq_pkg::MODE_W-1:0]        mode,
	input  logic                              thread_present,
	input  logic [rrq_pkg::ID_W-1:0]          thread_id,
	input  logic                              current_present,
	input  logic [rrq_pkg::ID_W-1:0]          current_id,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rrq_pkg::ID_W-1:0]          cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rrq_pkg::KIND_W-1:0]        kind,
	output logic [rrq_pkg::ID_W-1:0]          out_id,
	output logic                              last,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]  ready_count
);

	rrq_pkg::rrq_cmd_t    cmd;
	rrq_pkg::rrq_status_t status;

	rrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	rrq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.mode            (mode),
		.thread_present  (thread_present),
		.thread_id       (thread_id),
		.current_present (current_present),
		.current_id      (current_id),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.out_id          (out_id),
		.last            (last),
		.ready_count     (ready_count)
	);

endmodule

[sim/rrq_sched_sb_pkg.sv]
// result predictor and in-order checker for the round robin ready queue testbench
// keeps its own copy of the ready ring, zombie stack, running thread and idle id
// depends on rrq_pkg
package rrq_sched_sb_pkg;
	import rrq_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              tp;
		logic [ID_W-1:0]   tid;
		logic              cp;
		logic [ID_W-1:0]   cid;
	} sched_req_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   id;
		logic              last;
		logic [CNT_W-1:0]  count;
	} sched_beat_t;

	class sched_scoreboard;
		logic [ID_W-1:0] ring [DEPTH];
		logic [ID_W-1:0] zombies [DEPTH];
		int unsigned head;
		int unsigned ready_n;
		int unsigned zombie_n;
		logic [ID_W-1:0] run_id;
		bit run_ok;
		logic [ID_W-1:0] idle_id;
		sched_beat_t due_beats[$];
		sched_beat_t step_beats[$];
		int errors;

		function new();
			head = 0;
			ready_n = 0;
			zombie_n = 0;
			run_id = '0;
			run_ok = 1'b0;
			idle_id = IDLE_ID_RST;
			errors = 0;
		endfunction

		function void set_idle(input logic [ID_W-1:0] v);
			idle_id = v;
		endfunction

		function void add_beat(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id);
			sched_beat_t b;
			b = '0;
			b.kind = k;
			b.id = id;
			step_beats.push_back(b);
		endfunction

		function void yield_to(input bit cp, input logic [ID_W-1:0] cid);
			logic [ID_W-1:0] nxt;
			if (ready_n == 0) begin
				if (cp && cid == idle_id) begin
					add_beat(K_NOTHING, '0);
					return;
				end
				nxt = idle_id;
			end else begin
				nxt = ring[head];
				head = (head + 1) % DEPTH;
				ready_n--;
			end
			run_id = nxt;
			run_ok = 1'b1;
			add_beat(K_DISPATCH, nxt);
		endfunction

		function logic [KIND_W-1:0] reclaim_and_enqueue(input bit tp, input logic [ID_W-1:0] id);
			while (zombie_n > 0) begin
				zombie_n--;
				add_beat(K_RECLAIMED, zombies[zombie_n]);
			end
			if (!tp || id == idle_id)
				return K_IGNORED;
			if (ready_n >= DEPTH)
				return K_QFULL;
			ring[(head + ready_n) % DEPTH] = id;
			ready_n++;
			return K_NOTHING;
		endfunction

		function void terminate(input bit tp, input logic [ID_W-1:0] id, input bit cp,
			input logic [ID_W-1:0] cid);
			bit hit;
			hit = 1'b0;
			if (!tp || id == idle_id) begin
				add_beat(K_IGNORED, '0);
				return;
			end
			if (zombie_n >= DEPTH) begin
				add_beat(K_ZFULL, '0);
				return;
			end
			if (cp && id == cid) begin
				zombies[zombie_n] = id;
				zombie_n++;
				yield_to(cp, cid);
				return;
			end
			for (int i = 0; i < ready_n; i++) begin
				if (ring[(head + i) % DEPTH] == id) begin
					hit = 1'b1;
					for (int j = i; j + 1 < ready_n; j++)
						ring[(head + j) % DEPTH] = ring[(head + j + 1) % DEPTH];
					ready_n--;
					break;
				end
			end
			if (!hit && !(run_ok && id == run_id)) begin
				add_beat(K_IGNORED, '0);
				return;
			end
			zombies[zombie_n] = id;
			zombie_n++;
			add_beat(K_NOTHING, '0);
		endfunction

		function void note_request(input sched_req_t r);
			logic [KIND_W-1:0] st;
			step_beats.delete();
			case (r.mode)
			MODE_YIELD: yield_to(r.cp, r.cid);
			MODE_RESUME: begin
				st = reclaim_and_enqueue(r.tp, r.tid);
				add_beat(st, '0);
			end
			MODE_TERMINATE: terminate(r.tp, r.tid, r.cp, r.cid);
			MODE_PREEMPT: begin
				if (!r.cp) begin
					add_beat(K_IGNORED, '0);
				end else if (ready_n == 0) begin
					add_beat(K_NOTHING, '0);
				end else begin
					st = reclaim_and_enqueue(1'b1, r.cid);
					if (st == K_QFULL)
						add_beat(K_QFULL, '0);
					else
						yield_to(r.cp, r.cid);
				end
			end
			default: ;
			endcase
			foreach (step_beats[k]) begin
				step_beats[k].last = (k == step_beats.size() - 1);
				step_beats[k].count = CNT_W'(ready_n);
				due_beats.push_back(step_beats[k]);
			end
		endfunction

		function void compare(input string field, input logic [ID_W-1:0] want,
			input logic [ID_W-1:0] got, input real at_ns);
			if (got !== want) begin
				errors++;
				$display("%0.1f ns: %s expected %0d actual %0d", at_ns, field, want, got);
			end
		endfunction

		function void check_beat(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
			input logic last, input logic [CNT_W-1:0] count, input real at_ns);
			sched_beat_t want;
			if (due_beats.size() == 0) begin
				errors++;
				$display("%0.1f ns: beat expected none actual kind %0d id %0d last %0d count %0d",
					at_ns, kind, id, last, count);
				return;
			end
			want = due_beats.pop_front();
			compare("kind", ID_W'(want.kind), ID_W'(kind), at_ns);
			compare("out_id", want.id, id, at_ns);
			compare("last", ID_W'(want.last), ID_W'(last), at_ns);
			compare("ready_count", ID_W'(want.count), ID_W'(count), at_ns);
		endfunction
	endclass

endpackage

[sim/round_robin_ready_queue_tb.sv]
// testbench for the round robin ready queue: directed and random request streams
// with random sender bursts, receiver stalls and idle id changes, checked beat by beat
// depends on rrq_pkg, rrq_sched_sb_pkg and round_robin_ready_queue
module round_robin_ready_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rrq_pkg::*;
	import rrq_sched_sb_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;

	typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_style_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [MODE_W-1:0] mode;
	logic              thread_present;
	logic [ID_W-1:0]   thread_id;
	logic              current_present;
	logic [ID_W-1:0]   current_id;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [ID_W-1:0]   cfg_data;
	logic              out_valid;
	logic              out_ready;
	logic [KIND_W-1:0] kind;
	logic [ID_W-1:0]   out_id;
	logic              last;
	logic [CNT_W-1:0]  ready_count;

	sched_scoreboard sb;
	bit hold_req;
	rx_style_t rx_style;
	int rx_cycle;

	round_robin_ready_queue #(
		.QUEUE_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.thread_present(thread_present),
		.thread_id(thread_id),
		.current_present(current_present),
		.current_id(current_id),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.out_id(out_id),
		.last(last),
		.ready_count(ready_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		out_ready <= 1'b0;
		rx_style = RX_OPEN;
		rx_cycle = 0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle % 128 == 0)
				rx_style = rx_style_t'($urandom_range(0, 3));
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				case (rx_style)
				RX_OPEN: out_ready <= 1'b1;
				RX_HALF: out_ready <= 1'($urandom);
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (rx_cycle % 5 < 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_beat(kind, out_id, last, ready_count, $realtime);
	end

	function automatic sched_req_t req(input logic [MODE_W-1:0] m, input logic tp,
		input logic [ID_W-1:0] tid, input logic cp, input logic [ID_W-1:0] cid);
		sched_req_t r;
		r.mode = m;
		r.tp = tp;
		r.tid = tid;
		r.cp = cp;
		r.cid = cid;
		return r;
	endfunction

	function automatic logic [ID_W-1:0] cpu_id();
		return sb.run_ok ? sb.run_id : sb.idle_id;
	endfunction

	// tidy requests follow the running thread and target queued ids, the rest is noise
	function automatic sched_req_t pick_request(input bit tidy);
		sched_req_t r;
		int unsigned roll;
		r.mode = MODE_W'($urandom);
		r.tp = 1'($urandom);
		r.tid = ID_W'($urandom);
		r.cp = 1'($urandom);
		r.cid = ID_W'($urandom);
		if (!tidy)
			return r;
		roll = $urandom_range(0, 9);
		r.tp = 1'b1;
		r.cp = ($urandom_range(0, 7) != 0);
		r.cid = cpu_id();
		r.tid = ID_W'($urandom_range(1, 40));
		if (roll < 3) begin
			r.mode = MODE_YIELD;
		end else if (roll < 6) begin
			r.mode = MODE_RESUME;
		end else if (roll < 8) begin
			r.mode = MODE_TERMINATE;
			if (sb.ready_n > 0 && $urandom_range(0, 1))
				r.tid = sb.ring[(sb.head + $urandom_range(0, sb.ready_n - 1)) % DEPTH];
			else if ($urandom_range(0, 1))
				r.tid = r.cid;
		end else begin
			r.mode = MODE_PREEMPT;
		end
		return r;
	endfunction

	task automatic send(input sched_req_t r);
		in_valid <= 1'b1;
		mode <= r.mode;
		thread_present <= r.tp;
		thread_id <= r.tid;
		current_present <= r.cp;
		current_id <= r.cid;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_request(r);
	endtask

	task automatic gap(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.due_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_idle(input logic [ID_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_idle(v);
	endtask

	// full ring, wrapped compaction and a preempt that finds no room
	task automatic fill_queue();
		logic [ID_W-1:0] base;
		base = ID_W'($urandom_range(41, 200));
		for (int i = 0; i < DEPTH + 2; i++)
			send(req(MODE_RESUME, 1'b1, base + ID_W'(i), 1'b1, cpu_id()));
		send(req(MODE_PREEMPT, 1'b1, '0, 1'b1, base + ID_W'(1)));
		send(req(MODE_TERMINATE, 1'b1, base + ID_W'(5), 1'b0, '0));
		send(req(MODE_YIELD, 1'b0, '0, 1'b1, cpu_id()));
	endtask

	// full zombie stack, then one resume that reclaims all of it
	task automatic fill_zombies();
		logic [ID_W-1:0] victim;
		send(req(MODE_RESUME, 1'b1, ID_W'($urandom_range(41, 250)), 1'b1, cpu_id()));
		send(req(MODE_YIELD, 1'b0, '0, 1'b0, '0));
		victim = sb.run_id;
		for (int i = 0; i < DEPTH + 2; i++)
			send(req(MODE_TERMINATE, 1'b1, victim, 1'b0, '0));
		send(req(MODE_RESUME, 1'b1, ID_W'($urandom_range(1, 40)), 1'b1, cpu_id()));
	endtask

	task automatic run_directed();
		sched_req_t plan[$];
		plan.push_back(req(MODE_YIELD, 1'b0, 8'd0, 1'b0, 8'd0));
		plan.push_back(req(MODE_YIELD, 1'b0, 8'd0, 1'b1, 8'd255));
		plan.push_back(req(MODE_RESUME, 1'b0, 8'hAA, 1'b1, 8'd255));
		plan.push_back(req(MODE_RESUME, 1'b1, 8'd255, 1'b1, 8'd255));
		plan.push_back(req(MODE_RESUME, 1'b1, 8'd0, 1'b1, 8'd255));
		plan.push_back(req(MODE_RESUME, 1'b1, 8'd254, 1'b1, 8'd255));
		plan.push_back(req(MODE_TERMINATE, 1'b0, 8'd0, 1'b1, 8'd255));
		plan.push_back(req(MODE_TERMINATE, 1'b1, 8'd7, 1'b0, 8'd0));
		plan.push_back(req(MODE_TERMINATE, 1'b1, 8'd254, 1'b1, 8'd255));
		plan.push_back(req(MODE_PREEMPT, 1'b1, 8'd0, 1'b0, 8'd0));
		plan.push_back(req(MODE_PREEMPT, 1'b0, 8'd0, 1'b1, 8'd255));
		plan.push_back(req(MODE_PREEMPT, 1'b0, 8'd0, 1'b1, 8'd0));
		plan.push_back(req(MODE_TERMINATE, 1'b1, 8'd0, 1'b1, 8'd0));
		plan.push_back(req(MODE_RESUME, 1'b1, 8'd9, 1'b1, 8'd255));
		plan.push_back(req(MODE_TERMINATE, 1'b1, 8'd255, 1'b1, 8'd255));
		plan.push_back(req(MODE_YIELD, 1'b1, 8'd0, 1'b1, 8'd255));
		plan.push_back(req(MODE_TERMINATE, 1'b1, 8'd9, 1'b0, 8'd0));
		plan.push_back(req(MODE_RESUME, 1'b1, 8'h55, 1'b1, 8'd9));
		plan.push_back(req(MODE_PREEMPT, 1'b1, 8'd0, 1'b1, 8'hAA));
		plan.push_back(req(MODE_YIELD, 1'b0, 8'hFF, 1'b0, 8'hFF));
		plan.push_back(req(MODE_YIELD, 1'b1, 8'd0, 1'b1, 8'd0));
		foreach (plan[i]) begin
			send(plan[i]);
			gap($urandom_range(0, 2));
		end
	endtask

	task automatic run_random(input int n);
		int done_n;
		int burst;
		int roll;
		bit tidy;
		done_n = 0;
		while (done_n < n) begin
			roll = $urandom_range(0, 11);
			if (roll == 0) begin
				fill_queue();
				done_n += DEPTH + 5;
			end else if (roll == 1) begin
				fill_zombies();
				done_n += DEPTH + 5;
			end else begin
				burst = $urandom_range(1, 12);
				repeat (burst) begin
					tidy = ($urandom_range(0, 3) != 0);
					send(pick_request(tidy));
					done_n++;
				end
			end
			gap($urandom_range(0, 6));
		end
	endtask

	initial begin
		sb = new();
		hold_req = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_YIELD;
		thread_present <= 1'b0;
		thread_id <= '0;
		current_present <= 1'b0;
		current_id <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		write_idle(8'd0);
		run_random(90);
		write_idle(ID_W'($urandom_range(1, 254)));
		hold_req = 1'b1;
		run_random(90);
		write_idle(8'd255);
		run_random(90);
		write_idle(ID_W'($urandom_range(0, 255)));
		run_random(90);
		drain();

		if (sb.errors == 0 && sb.due_beats.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
